// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tls_pkg.sv -----
// ---------------------------------------------------------------------------
// tls_pkg
// Types and constants of the traffic light sequencer.
// ---------------------------------------------------------------------------
package tls_pkg;

   localparam int unsigned TICK_W     = 20;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 16;

   typedef logic [TICK_W-1:0] tick_type;

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_NORMAL,
      MODE_YBLINK,
      MODE_PED
   } mode_type;

   typedef enum logic [2:0] {
      PH_GREEN,
      PH_GBLINK,
      PH_YELLOW,
      PH_RED,
      PH_RED_AMBER
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GREEN,
      CSR_GREEN_BLINK,
      CSR_YELLOW,
      CSR_RED,
      CSR_RED_AMBER,
      CSR_CROSSING,
      CSR_BLINK_PERIOD,
      CSR_WALK_DEBOUNCE
   } csr_addr_type;

   typedef struct packed {
      logic red;
      logic yellow;
      logic green;
   } lamps_type;

   localparam lamps_type LAMPS_OFF = '{red: 1'b0, yellow: 1'b0, green: 1'b0};
   localparam lamps_type LAMPS_GRN = '{red: 1'b0, yellow: 1'b0, green: 1'b1};
   localparam lamps_type LAMPS_YEL = '{red: 1'b0, yellow: 1'b1, green: 1'b0};
   localparam lamps_type LAMPS_RED = '{red: 1'b1, yellow: 1'b0, green: 1'b0};
   localparam lamps_type LAMPS_RY  = '{red: 1'b1, yellow: 1'b1, green: 1'b0};

   typedef struct packed {
      tick_type green;
      tick_type green_blink;
      tick_type yellow;
      tick_type red;
      tick_type red_amber;
      tick_type crossing;
      tick_type blink_period;
      tick_type walk_debounce;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      green:         TICK_W'(10000),
      green_blink:   TICK_W'(3000),
      yellow:        TICK_W'(2000),
      red:           TICK_W'(10000),
      red_amber:     TICK_W'(1000),
      crossing:      TICK_W'(8000),
      blink_period:  TICK_W'(500),
      walk_debounce: TICK_W'(50)
   };

   typedef struct packed {
      mode_type  mode;
      phase_type phase;
      lamps_type lamps;
      tick_type  phase_rem;
      tick_type  blink_rem;
      tick_type  walk_deb_rem;
      tick_type  mode_deb_rem;
      logic      walk_last;
      logic      mode_last;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_OFF,
      phase:        PH_GREEN,
      lamps:        LAMPS_OFF,
      phase_rem:    '0,
      blink_rem:    '0,
      walk_deb_rem: '0,
      mode_deb_rem: '0,
      walk_last:    1'b1,
      mode_last:    1'b1
   };

   // request fields, lowest bit last
   typedef struct packed {
      logic [1:0] request_mode;
      logic       request_valid;
      logic       walk_button;
      logic       mode_button;
   } item_type;

   // response fields, lowest bit last
   typedef struct packed {
      logic [2:0] phase_now;
      logic [1:0] mode_now;
      logic       walk_green;
      logic       walk_red;
      logic       lamp_green;
      logic       lamp_yellow;
      logic       lamp_red;
   } result_type;

endpackage

// ----- hdl/tls_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// tls_cfg_regs
// Timing registers, written through the CSR port.
// ---------------------------------------------------------------------------
module tls_cfg_regs
   import tls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  tick_type              csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_GREEN:         cfg_in.green         = csr_wdata;
            CSR_GREEN_BLINK:   cfg_in.green_blink   = csr_wdata;
            CSR_YELLOW:        cfg_in.yellow        = csr_wdata;
            CSR_RED:           cfg_in.red           = csr_wdata;
            CSR_RED_AMBER:     cfg_in.red_amber     = csr_wdata;
            CSR_CROSSING:      cfg_in.crossing      = csr_wdata;
            CSR_BLINK_PERIOD:  cfg_in.blink_period  = csr_wdata;
            CSR_WALK_DEBOUNCE: cfg_in.walk_debounce = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/tls_tick_core.sv -----
// ---------------------------------------------------------------------------
// tls_tick_core
// Next-state logic for one timer tick: counters, then events in order.
// ---------------------------------------------------------------------------
module tls_tick_core
   import tls_pkg::*;
#(
   parameter int unsigned MODE_DEBOUNCE_TICKS = 50
)
(
   input  state_type cur,
   input  item_type  item,
   input  cfg_type   cfg,
   output state_type nxt
);

   localparam tick_type MODE_DEB = TICK_W'(MODE_DEBOUNCE_TICKS);

   function automatic state_type go_phase(state_type s, phase_type p, cfg_type c);
      state_type r;
      r       = s;
      r.phase = p;
      unique case (p)
         PH_GREEN: begin
            r.lamps = LAMPS_GRN;
            if (s.mode == MODE_NORMAL) r.phase_rem = c.green;
         end
         PH_GBLINK: begin
            r.lamps     = LAMPS_GRN;
            r.phase_rem = c.green_blink;
            r.blink_rem = c.blink_period;
         end
         PH_YELLOW: begin
            r.lamps     = LAMPS_YEL;
            r.phase_rem = c.yellow;
         end
         PH_RED: begin
            r.lamps     = LAMPS_RED;
            r.phase_rem = (s.mode == MODE_PED) ? c.crossing : c.red;
         end
         default: begin
            r.lamps     = LAMPS_RY;
            r.phase_rem = c.red_amber;
         end
      endcase
      return r;
   endfunction

   // caller drops the pending phase and blink events
   function automatic state_type change_mode(state_type s, mode_type m, cfg_type c);
      state_type r;
      r           = s;
      r.phase_rem = '0;
      r.blink_rem = '0;
      r.mode      = m;
      unique case (m)
         MODE_NORMAL, MODE_PED: r = go_phase(r, PH_GREEN, c);
         MODE_YBLINK: begin
            r.lamps     = LAMPS_YEL;
            r.blink_rem = c.blink_period;
         end
         default: r.lamps = LAMPS_OFF;
      endcase
      return r;
   endfunction

   always_comb begin
      state_type s;
      logic      ev_phase;
      logic      ev_blink;
      logic      ev_walk;
      logic      ev_mode;

      s        = cur;
      ev_phase = 1'b0;
      ev_blink = 1'b0;
      ev_walk  = 1'b0;
      ev_mode  = 1'b0;

      if (cur.phase_rem != '0) begin
         s.phase_rem = cur.phase_rem - 1'b1;
         ev_phase    = (s.phase_rem == '0);
      end
      if (cur.blink_rem != '0) begin
         s.blink_rem = cur.blink_rem - 1'b1;
         if (s.blink_rem == '0) begin
            ev_blink    = 1'b1;
            s.blink_rem = cfg.blink_period;
         end
      end

      if (cur.walk_last && !item.walk_button) begin
         s.walk_deb_rem = cfg.walk_debounce;
      end else if (cur.walk_deb_rem != '0) begin
         s.walk_deb_rem = cur.walk_deb_rem - 1'b1;
         ev_walk        = (s.walk_deb_rem == '0) && !item.walk_button;
      end
      if (cur.mode_last && !item.mode_button) begin
         s.mode_deb_rem = MODE_DEB;
      end else if (cur.mode_deb_rem != '0) begin
         s.mode_deb_rem = cur.mode_deb_rem - 1'b1;
         ev_mode        = (s.mode_deb_rem == '0) && !item.mode_button;
      end
      s.walk_last = item.walk_button;
      s.mode_last = item.mode_button;

      if (item.request_valid && (mode_type'(item.request_mode) != s.mode)) begin
         s        = change_mode(s, mode_type'(item.request_mode), cfg);
         ev_phase = 1'b0;
         ev_blink = 1'b0;
      end

      if (ev_phase) begin
         unique case (s.phase)
            PH_GREEN:  s = go_phase(s, PH_GBLINK, cfg);
            PH_GBLINK: begin
               s.blink_rem = '0;
               ev_blink    = 1'b0;
               s           = go_phase(s, PH_YELLOW, cfg);
            end
            PH_YELLOW:    s = go_phase(s, PH_RED, cfg);
            PH_RED:       s = go_phase(s, PH_RED_AMBER, cfg);
            PH_RED_AMBER: s = go_phase(s, PH_GREEN, cfg);
            default:      s = s;
         endcase
      end

      if (ev_blink) begin
         if (s.mode == MODE_YBLINK) begin
            s.lamps = s.lamps.yellow ? LAMPS_OFF : LAMPS_YEL;
         end else if ((s.mode == MODE_NORMAL || s.mode == MODE_PED) &&
                      s.phase == PH_GBLINK) begin
            s.lamps = s.lamps.green ? LAMPS_OFF : LAMPS_GRN;
         end
      end

      if (ev_walk && s.mode == MODE_PED && s.phase == PH_GREEN) begin
         s = go_phase(s, PH_GBLINK, cfg);
      end

      if (ev_mode) begin
         s = change_mode(s, mode_type'(s.mode + 2'd1), cfg);
      end

      nxt = s;
   end

endmodule

// ----- hdl/traffic_light_sequencer.sv -----
// A request is captured in the input register; its response is then registered
// together with the new state (state and response register).
// Throughput: one request per cycle; both stages advance together whenever the
// response register is empty or being taken.
// Reset (synchronous): mode off, phase green, lamps off, counters stopped,
// buttons released, timing registers back to their defaults.
`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// traffic_light_sequencer
// Tick-driven traffic light controller with pedestrian request and debounce.
// ---------------------------------------------------------------------------
module traffic_light_sequencer
   import tls_pkg::*;
#(
   parameter int unsigned MODE_DEBOUNCE_TICKS = 50
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode_button, walk_button, request_valid, request_mode[1:0], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // lamp_red, lamp_yellow, lamp_green, walk_red, walk_green, mode_now[1:0],
   // phase_now[2:0], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  tick_type              csr_wdata
);

   cfg_type    cfg;
   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;
   state_type  state_ff;
   state_type  state_in;
   logic       advance;
   logic       red_only;

   tls_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tls_tick_core #(
      .MODE_DEBOUNCE_TICKS (MODE_DEBOUNCE_TICKS)
   ) u_core (
      .cur  (state_ff),
      .item (in_item_ff),
      .cfg  (cfg),
      .nxt  (state_in)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      red_only           = state_in.lamps.red && !state_in.lamps.yellow;
      out_in.lamp_red    = state_in.lamps.red;
      out_in.lamp_yellow = state_in.lamps.yellow;
      out_in.lamp_green  = state_in.lamps.green;
      out_in.walk_red    = (state_in.mode == MODE_PED) && !red_only;
      out_in.walk_green  = (state_in.mode == MODE_PED) && red_only;
      out_in.mode_now    = state_in.mode;
      out_in.phase_now   = state_in.phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) in_item_ff <= item_type'(req_tdata[$bits(item_type)-1:0]);
      if (advance)    out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);

   `ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff, "request lost on advance")
   `ASSERT_IMPL(a_off_dark, clock, reset, state_ff.mode == MODE_OFF, state_ff.lamps == LAMPS_OFF, "lamps lit in off mode")
   `ASSERT_IMPL(a_yblink_yellow, clock, reset, state_ff.mode == MODE_YBLINK, !state_ff.lamps.red && !state_ff.lamps.green, "red or green lit while blinking yellow")
   `ASSERT_IMPL(a_ped_green_holds, clock, reset, state_ff.mode == MODE_PED && state_ff.phase == PH_GREEN, state_ff.phase_rem == '0, "phase timer runs in pedestrian green")

endmodule

// ----- tb/tb_traffic_light_sequencer.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_traffic_light_sequencer
// Feeds timer ticks with button levels and mode requests into the sequencer,
// predicts lamps, mode and phase for every tick under several timing setups,
// and checks every response in order while both sides of the stream stall.
// ---------------------------------------------------------------------------
module tb_traffic_light_sequencer
   import tls_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MODE_SETTLE = 50;
   localparam int unsigned TICKS_PER_SETUP = 200;
   localparam tick_type TICK_MAX = '1;

   typedef enum int unsigned {
      TIMING_DIRECTED,
      TIMING_ALL_ONE,
      TIMING_ALL_MAX,
      TIMING_MIXED_MAX,
      TIMING_SHORT
   } timing_style_type;

   localparam tick_type DIRECTED_TIMING [8] = '{
      20'd2, 20'd3, 20'd1, 20'd2, 20'd1, 20'd2, 20'd1, 20'd1
   };
   localparam timing_style_type RANDOM_PLAN [7] = '{
      TIMING_SHORT, TIMING_ALL_ONE, TIMING_MIXED_MAX, TIMING_SHORT,
      TIMING_ALL_MAX, TIMING_SHORT, TIMING_SHORT
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // mode_button, walk_button, request_valid, request_mode[1:0], zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // lamp_red, lamp_yellow, lamp_green, walk_red, walk_green, mode_now[1:0],
   // phase_now[2:0], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   tick_type              csr_wdata = '0;

   traffic_light_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // controller prediction state
   tick_type  dur [8];
   mode_type  lt_mode;
   phase_type lt_phase;
   lamps_type lt_lamps;
   tick_type  phase_left, blink_left, walk_settle, mode_settle;
   logic      walk_was_up, mode_was_up;
   logic      phase_due, blink_due;

   item_type   ticks_waiting [$];
   result_type lights_due [$];
   item_type   offered = '0;

   int unsigned burst_left = 0, gap_left = 0;
   int unsigned hold_asks = 0, holds_served = 0, hold_left = 0;
   int unsigned stall_style = 0, pattern_left = 0;
   int unsigned cycle_count = 0, mismatches = 0, ticks_checked = 0;
   int unsigned mode_changes = 0, phase_steps = 0, setups = 0;

   task automatic reset_model();
      dur = '{20'd10000, 20'd3000, 20'd2000, 20'd10000,
              20'd1000, 20'd8000, 20'd500, 20'd50};
      lt_mode     = MODE_OFF;
      lt_phase    = PH_GREEN;
      lt_lamps    = LAMPS_OFF;
      phase_left  = '0;
      blink_left  = '0;
      walk_settle = '0;
      mode_settle = '0;
      walk_was_up = 1'b1;
      mode_was_up = 1'b1;
      phase_due   = 1'b0;
      blink_due   = 1'b0;
   endtask

   task automatic enter_phase(input phase_type p);
      lt_phase = p;
      phase_steps++;
      case (p)
         PH_GREEN: begin
            lt_lamps = LAMPS_GRN;
            if (lt_mode == MODE_NORMAL) phase_left = dur[CSR_GREEN];
         end
         PH_GBLINK: begin
            lt_lamps   = LAMPS_GRN;
            phase_left = dur[CSR_GREEN_BLINK];
            blink_left = dur[CSR_BLINK_PERIOD];
         end
         PH_YELLOW: begin
            lt_lamps   = LAMPS_YEL;
            phase_left = dur[CSR_YELLOW];
         end
         PH_RED: begin
            lt_lamps   = LAMPS_RED;
            phase_left = (lt_mode == MODE_PED) ? dur[CSR_CROSSING] : dur[CSR_RED];
         end
         default: begin
            lt_lamps   = LAMPS_RY;
            phase_left = dur[CSR_RED_AMBER];
         end
      endcase
   endtask

   task automatic switch_mode(input mode_type m);
      if (m != lt_mode) begin
         phase_left = '0;
         phase_due  = 1'b0;
         blink_left = '0;
         blink_due  = 1'b0;
         lt_mode    = m;
         mode_changes++;
         case (m)
            MODE_NORMAL, MODE_PED: enter_phase(PH_GREEN);
            MODE_YBLINK: begin
               lt_lamps   = LAMPS_YEL;
               blink_left = dur[CSR_BLINK_PERIOD];
            end
            default: lt_lamps = LAMPS_OFF;
         endcase
      end
   endtask

   task automatic step_controller(input item_type it, output result_type r);
      logic       walk_hit, mode_hit, red_only;
      logic [1:0] next_mode;
      walk_hit  = 1'b0;
      mode_hit  = 1'b0;
      phase_due = 1'b0;
      blink_due = 1'b0;

      if (phase_left != 0) begin
         phase_left--;
         if (phase_left == 0) phase_due = 1'b1;
      end
      if (blink_left != 0) begin
         blink_left--;
         if (blink_left == 0) begin
            blink_due  = 1'b1;
            blink_left = dur[CSR_BLINK_PERIOD];
         end
      end
      if (walk_was_up && !it.walk_button) begin
         walk_settle = dur[CSR_WALK_DEBOUNCE];
      end else if (walk_settle != 0) begin
         walk_settle--;
         if (walk_settle == 0 && !it.walk_button) walk_hit = 1'b1;
      end
      if (mode_was_up && !it.mode_button) begin
         mode_settle = tick_type'(MODE_SETTLE);
      end else if (mode_settle != 0) begin
         mode_settle--;
         if (mode_settle == 0 && !it.mode_button) mode_hit = 1'b1;
      end
      walk_was_up = it.walk_button;
      mode_was_up = it.mode_button;

      if (it.request_valid) switch_mode(mode_type'(it.request_mode));

      if (phase_due) begin
         phase_due = 1'b0;
         case (lt_phase)
            PH_GREEN:  enter_phase(PH_GBLINK);
            PH_GBLINK: begin
               blink_left = '0;
               blink_due  = 1'b0;
               enter_phase(PH_YELLOW);
            end
            PH_YELLOW: enter_phase(PH_RED);
            PH_RED:    enter_phase(PH_RED_AMBER);
            default:   enter_phase(PH_GREEN);
         endcase
      end

      if (blink_due) begin
         blink_due = 1'b0;
         if (lt_mode == MODE_YBLINK) begin
            lt_lamps = lt_lamps.yellow ? LAMPS_OFF : LAMPS_YEL;
         end else if ((lt_mode == MODE_NORMAL || lt_mode == MODE_PED)
                      && lt_phase == PH_GBLINK) begin
            lt_lamps = lt_lamps.green ? LAMPS_OFF : LAMPS_GRN;
         end
      end

      if (walk_hit && lt_mode == MODE_PED && lt_phase == PH_GREEN) enter_phase(PH_GBLINK);

      if (mode_hit) begin
         next_mode = lt_mode + 2'd1;
         switch_mode(mode_type'(next_mode));
      end

      red_only     = lt_lamps.red && !lt_lamps.yellow;
      r.lamp_red    = lt_lamps.red;
      r.lamp_yellow = lt_lamps.yellow;
      r.lamp_green  = lt_lamps.green;
      r.walk_red    = (lt_mode == MODE_PED) && !red_only;
      r.walk_green  = (lt_mode == MODE_PED) && red_only;
      r.mode_now    = lt_mode;
      r.phase_now   = lt_phase;
   endtask

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      logic       offer;
      result_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            step_controller(offered, r);
            lights_due.push_back(r);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (ticks_waiting.size() != 0) begin
               offered = ticks_waiting.pop_front();
               offer   = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 3) == 1 ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left--;
               end
            end
         end
         req_tvalid <= offer;
         req_tdata  <= REQ_DATA_W'(offered);
      end
   end

   // response stall pattern, with long hold-offs on request
   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (holds_served != hold_asks) begin
            holds_served++;
            hold_left = $urandom_range(40, 90);
            rdy = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_style)
               0: rdy = 1'b1;
               1: rdy = 1'($urandom_range(0, 1));
               2: rdy = ($urandom_range(0, 3) == 0);
               default: rdy = (pattern_left[2:0] != 3'd0);
            endcase
         end
         rsp_tready <= rdy;
      end
   end

   // response checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (lights_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response %h with no request pending", rsp_tdata);
         end else begin
            want = lights_due.pop_front();
            ticks_checked++;
            if (got.lamp_red !== want.lamp_red || got.lamp_yellow !== want.lamp_yellow
                || got.lamp_green !== want.lamp_green || got.walk_red !== want.walk_red
                || got.walk_green !== want.walk_green || got.mode_now !== want.mode_now
                || got.phase_now !== want.phase_now) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tick %0d: expected RYG %b%b%b walk r%b g%b mode %0d phase %0d, got RYG %b%b%b walk r%b g%b mode %0d phase %0d",
                           ticks_checked, want.lamp_red, want.lamp_yellow, want.lamp_green,
                           want.walk_red, want.walk_green, want.mode_now, want.phase_now,
                           got.lamp_red, got.lamp_yellow, got.lamp_green,
                           got.walk_red, got.walk_green, got.mode_now, got.phase_now);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", lights_due.size());
         $display("FAIL traffic_light_sequencer");
         $finish;
      end
   end

   task automatic push_tick(input logic mb, input logic wb, input logic rv,
                            input logic [1:0] rm);
      item_type it;
      it.mode_button   = mb;
      it.walk_button   = wb;
      it.request_valid = rv;
      it.request_mode  = rm;
      ticks_waiting.push_back(it);
   endtask

   // button levels with an occasional software request mixed in
   task automatic push_levels(input logic mb, input logic wb);
      push_tick(mb, wb, $urandom_range(0, 39) == 0, 2'($urandom_range(0, 3)));
   endtask

   task automatic wait_quiet();
      while (ticks_waiting.size() != 0 || req_tvalid || lights_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_timing(input timing_style_type style);
      tick_type v;
      for (int i = 0; i < 8; i++) begin
         case (style)
            TIMING_DIRECTED:  v = DIRECTED_TIMING[i];
            TIMING_ALL_ONE:   v = 20'd1;
            TIMING_ALL_MAX:   v = TICK_MAX;
            TIMING_MIXED_MAX: v = (i == 0 || $urandom_range(0, 1)) ? TICK_MAX
                                                                   : tick_type'($urandom_range(1, 6));
            default:          v = tick_type'($urandom_range(1, 12));
         endcase
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(i);
         csr_wdata <= v;
         dur[i] = v;
      end
      @(posedge clock);
      csr_we <= 1'b0;
      setups++;
   endtask

   task automatic queue_random_ticks(input int unsigned count);
      int unsigned made, len;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 9))
            0: begin
               // mode press, some released before the debounce runs out
               len = $urandom_range(40, 60);
               repeat (len) push_levels(1'b0, 1'b1);
            end
            1, 2, 3: begin
               len = $urandom_range(1, 14);
               repeat (len) push_levels(1'b1, 1'b0);
            end
            4: begin
               len = $urandom_range(1, 6);
               repeat (len) push_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            default: begin
               len = $urandom_range(1, 16);
               repeat (len) push_levels(1'b1, 1'b1);
            end
         endcase
         made += len;
      end
   endtask

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_timing(TIMING_DIRECTED);
      push_tick(1'b1, 1'b1, 1'b0, MODE_OFF);
      push_tick(1'b1, 1'b1, 1'b1, MODE_OFF);       // same mode, no change
      push_tick(1'b1, 1'b1, 1'b1, MODE_YBLINK);
      repeat (3) push_tick(1'b1, 1'b1, 1'b0, MODE_NORMAL);
      push_tick(1'b1, 1'b1, 1'b1, MODE_NORMAL);
      repeat (9) push_tick(1'b1, 1'b1, 1'b0, MODE_PED);  // full normal cycle
      push_tick(1'b1, 1'b1, 1'b1, MODE_NORMAL);
      push_tick(1'b1, 1'b1, 1'b1, MODE_PED);       // green holds, no timer
      push_tick(1'b1, 1'b0, 1'b0, MODE_OFF);       // walk press
      push_tick(1'b1, 1'b0, 1'b0, MODE_OFF);
      repeat (5) push_tick(1'b1, 1'b1, 1'b0, MODE_YBLINK);  // into crossing
      push_tick(1'b0, 1'b0, 1'b1, MODE_OFF);       // walk ignored outside ped green
      push_tick(1'b1, 1'b1, 1'b0, MODE_PED);
      wait_quiet();

      foreach (RANDOM_PLAN[i]) begin
         load_timing(RANDOM_PLAN[i]);
         if (i == 0 || i == 3) hold_asks++;
         queue_random_ticks(TICKS_PER_SETUP);
         wait_quiet();
      end

      $display("checked %0d ticks over %0d timing setups", ticks_checked, setups);
      $display("predicted %0d mode changes and %0d phase steps", mode_changes, phase_steps);
      if (mismatches == 0) begin
         $display("PASS traffic_light_sequencer");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL traffic_light_sequencer");
      end
      $finish;
   end

endmodule
